// ===== rtl/core/vmws_pkg.sv =====
// Types, constants and elaboration-time tables for the vector median window select core.
`default_nettype none

package vmws_pkg;

   localparam int NUM_ROWS     = 3;
   localparam int NUM_COLS     = 3;
   localparam int NUM_POS      = NUM_ROWS * NUM_COLS;
   localparam int NUM_PAIRS    = NUM_POS * (NUM_POS - 1) / 2;
   localparam int POS_PAIRS_N  = NUM_POS - 1;
   localparam int PART_N       = 2;
   localparam int PART_SIZE    = POS_PAIRS_N / PART_N;
   localparam int GROUP_N      = 3;
   localparam int GROUP_SIZE   = NUM_POS / GROUP_N;
   localparam int CHAN_MAX     = 3;
   localparam int CHAN_W       = 8;
   localparam int PIXEL_W      = CHAN_MAX * CHAN_W;
   localparam int POS_W        = 4;
   localparam int PAIR_IDX_W   = 6;
   localparam int DIFF_W       = CHAN_W;
   localparam int TERM_W       = 2 * CHAN_W;
   localparam int PAIR_W       = TERM_W + 2;
   localparam int PART_W       = PAIR_W + 2;
   localparam int TOTAL_W      = PART_W + 1;

   // pipeline stage numbers
   localparam int ST_DIFF      = 1;
   localparam int ST_TERM      = 2;
   localparam int ST_PAIR      = 3;
   localparam int ST_PART      = 4;
   localparam int ST_TOTAL     = 5;
   localparam int ST_GROUP     = 6;
   localparam int ST_OUT       = 7;
   localparam int NUM_STAGES   = ST_OUT;

   typedef logic [PIXEL_W-1:0]    pixel_type;
   typedef logic [TOTAL_W-1:0]    total_type;
   typedef logic [POS_W-1:0]      pos_type;
   typedef logic [NUM_POS-1:0]    pos_mask_type;
   typedef logic [PAIR_IDX_W-1:0] pair_idx_type;
   typedef logic [PAIR_W-1:0]     pair_dist_type;

   typedef pos_type [NUM_PAIRS-1:0]            pair_end_type;
   typedef pair_idx_type [POS_PAIRS_N-1:0]     pos_pair_list_type;
   typedef pos_pair_list_type [NUM_POS-1:0]    pos_pair_table_type;

   typedef enum logic [0:0] {
      MODE_ABS    = 1'b0,
      MODE_SQUARE = 1'b1
   } distance_mode_type;

   typedef struct packed {
      logic [NUM_STAGES:1] en;
   } stage_ctl_type;

   typedef struct packed {
      pixel_type pixel;
      pos_type   pos;
      total_type total;
   } result_type;

   function automatic pair_end_type pair_lo_table();
      pair_end_type t;
      int p;
      t = '0;
      p = 0;
      for (int a = 0; a < NUM_POS; a++) begin
         for (int b = a + 1; b < NUM_POS; b++) begin
            t[p] = POS_W'(a);
            p++;
         end
      end
      return t;
   endfunction

   function automatic pair_end_type pair_hi_table();
      pair_end_type t;
      int p;
      t = '0;
      p = 0;
      for (int a = 0; a < NUM_POS; a++) begin
         for (int b = a + 1; b < NUM_POS; b++) begin
            t[p] = POS_W'(b);
            p++;
         end
      end
      return t;
   endfunction

   // for each position, the pairs it belongs to
   function automatic pos_pair_table_type pos_pair_table();
      pos_pair_table_type t;
      int fill [NUM_POS];
      int p;
      t = '0;
      p = 0;
      for (int k = 0; k < NUM_POS; k++) begin
         fill[k] = 0;
      end
      for (int a = 0; a < NUM_POS; a++) begin
         for (int b = a + 1; b < NUM_POS; b++) begin
            t[a][fill[a]] = PAIR_IDX_W'(p);
            fill[a]++;
            t[b][fill[b]] = PAIR_IDX_W'(p);
            fill[b]++;
            p++;
         end
      end
      return t;
   endfunction

   function automatic pos_mask_type window_mask(int half_w, int half_h);
      pos_mask_type m;
      int dr;
      int dc;
      m = '0;
      for (int r = 0; r < NUM_ROWS; r++) begin
         for (int c = 0; c < NUM_COLS; c++) begin
            dr = (r > 1) ? r - 1 : 1 - r;
            dc = (c > 1) ? c - 1 : 1 - c;
            m[r * NUM_COLS + c] = (dc <= half_w) && (dr <= half_h);
         end
      end
      return m;
   endfunction

   function automatic pixel_type chan_keep(int n);
      pixel_type m;
      m = '0;
      for (int c = 0; c < CHAN_MAX; c++) begin
         if (c < n) begin
            m[c * CHAN_W +: CHAN_W] = '1;
         end
      end
      return m;
   endfunction

   localparam pair_end_type       PAIR_LO   = pair_lo_table();
   localparam pair_end_type       PAIR_HI   = pair_hi_table();
   localparam pos_pair_table_type POS_PAIRS = pos_pair_table();

endpackage

`default_nettype wire

// ===== rtl/core/vmws_channels.sv =====
// Handshake channel interfaces: window items in, selected pixels out, mode register writes.
`default_nettype none

interface vmws_req_if import vmws_pkg::*; ();
   logic         valid;
   logic         ready;
   pixel_type    pixel_0;
   pixel_type    pixel_1;
   pixel_type    pixel_2;
   pixel_type    pixel_3;
   pixel_type    pixel_4;
   pixel_type    pixel_5;
   pixel_type    pixel_6;
   pixel_type    pixel_7;
   pixel_type    pixel_8;
   pos_mask_type valid_mask;

   modport source (
      output valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5, pixel_6,
             pixel_7, pixel_8, valid_mask,
      input  ready
   );
   modport sink (
      input  valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5, pixel_6,
             pixel_7, pixel_8, valid_mask,
      output ready
   );
endinterface

interface vmws_rsp_if import vmws_pkg::*; ();
   logic      valid;
   logic      ready;
   pixel_type filtered_pixel;
   pos_type   chosen_position;
   total_type least_total;

   modport source (
      output valid, filtered_pixel, chosen_position, least_total,
      input  ready
   );
   modport sink (
      input  valid, filtered_pixel, chosen_position, least_total,
      output ready
   );
endinterface

interface vmws_csr_if import vmws_pkg::*; ();
   logic valid;
   logic ready;
   logic distance_mode;

   modport source (
      output valid, distance_mode,
      input  ready
   );
   modport sink (
      input  valid, distance_mode,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/core/vmws_pair_dist.sv =====
// One pair lane: channel differences, absolute or squared terms, masked pair distance.
`default_nettype none

module vmws_pair_dist import vmws_pkg::*; #(
   parameter int CHANNEL_COUNT = 3
) (
   input  logic              clock,
   input  stage_ctl_type     ctl,
   input  pixel_type         pixel_a,
   input  pixel_type         pixel_b,
   input  logic              pair_used,
   input  distance_mode_type mode,
   output pair_dist_type     pair_dist
);

   logic [DIFF_W-1:0] diff_in  [CHANNEL_COUNT];
   logic [DIFF_W-1:0] diff_ff  [CHANNEL_COUNT];
   logic [TERM_W-1:0] term_in  [CHANNEL_COUNT];
   logic [TERM_W-1:0] term_ff  [CHANNEL_COUNT];
   logic              used_1_ff;
   logic              used_2_ff;
   pair_dist_type     dist_in;
   pair_dist_type     dist_ff;

   always_comb begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
         if (pixel_a[c * CHAN_W +: CHAN_W] > pixel_b[c * CHAN_W +: CHAN_W]) begin
            diff_in[c] = pixel_a[c * CHAN_W +: CHAN_W] - pixel_b[c * CHAN_W +: CHAN_W];
         end else begin
            diff_in[c] = pixel_b[c * CHAN_W +: CHAN_W] - pixel_a[c * CHAN_W +: CHAN_W];
         end
      end
   end

   always_comb begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
         if (mode == MODE_SQUARE) begin
            term_in[c] = TERM_W'(diff_ff[c]) * TERM_W'(diff_ff[c]);
         end else begin
            term_in[c] = TERM_W'(diff_ff[c]);
         end
      end
   end

   always_comb begin
      dist_in = '0;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
         dist_in = dist_in + PAIR_W'(term_ff[c]);
      end
      if (!used_2_ff) begin
         dist_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en[ST_DIFF]) begin
         diff_ff   <= diff_in;
         used_1_ff <= pair_used;
      end
      if (ctl.en[ST_TERM]) begin
         term_ff   <= term_in;
         used_2_ff <= used_1_ff;
      end
      if (ctl.en[ST_PAIR]) begin
         dist_ff   <= dist_in;
      end
   end

   assign pair_dist = dist_ff;

endmodule

`default_nettype wire

// ===== rtl/core/vmws_min_select.sv =====
// Two-stage least-total search over the window, first raster position winning ties.
`default_nettype none

module vmws_min_select import vmws_pkg::*; (
   input  logic          clock,
   input  stage_ctl_type ctl,
   input  total_type     total [NUM_POS],
   input  pixel_type     pixel [NUM_POS],
   input  pos_mask_type  used,
   output result_type    result
);

   logic      grp_found_in [GROUP_N];
   total_type grp_total_in [GROUP_N];
   pos_type   grp_pos_in   [GROUP_N];
   pixel_type grp_pix_in   [GROUP_N];
   logic      grp_found_ff [GROUP_N];
   total_type grp_total_ff [GROUP_N];
   pos_type   grp_pos_ff   [GROUP_N];
   pixel_type grp_pix_ff   [GROUP_N];
   logic      found;
   result_type result_in;
   result_type result_ff;

   always_comb begin
      for (int g = 0; g < GROUP_N; g++) begin
         grp_found_in[g] = 1'b0;
         grp_total_in[g] = '0;
         grp_pos_in[g]   = '0;
         grp_pix_in[g]   = '0;
         for (int i = 0; i < GROUP_SIZE; i++) begin
            if (used[g * GROUP_SIZE + i] &&
                (!grp_found_in[g] || total[g * GROUP_SIZE + i] < grp_total_in[g])) begin
               grp_found_in[g] = 1'b1;
               grp_total_in[g] = total[g * GROUP_SIZE + i];
               grp_pos_in[g]   = POS_W'(g * GROUP_SIZE + i);
               grp_pix_in[g]   = pixel[g * GROUP_SIZE + i];
            end
         end
      end
   end

   // no usable position leaves the result all zero
   always_comb begin
      found     = 1'b0;
      result_in = '0;
      for (int g = 0; g < GROUP_N; g++) begin
         if (grp_found_ff[g] && (!found || grp_total_ff[g] < result_in.total)) begin
            found           = 1'b1;
            result_in.total = grp_total_ff[g];
            result_in.pos   = grp_pos_ff[g];
            result_in.pixel = grp_pix_ff[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en[ST_GROUP]) begin
         grp_found_ff <= grp_found_in;
         grp_total_ff <= grp_total_in;
         grp_pos_ff   <= grp_pos_in;
         grp_pix_ff   <= grp_pix_in;
      end
      if (ctl.en[ST_OUT]) begin
         result_ff    <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

// ===== rtl/core/vector_median_window_select_core.sv =====
// Top level of the vector median window select core.
`default_nettype none

// Takes one 3x3 window of packed pixels per item and returns the masked-in pixel whose summed
// distance to all other masked-in pixels is least (absolute or squared channel differences,
// chosen by the mode register), its raster position and that total. One item is accepted
// every cycle unless back-pressure holds the input. The seven register stages are: channel
// differences, terms (one 8x8 multiplier per pair and channel across 36 pair lanes), pair
// sums, half totals, totals, group minimum and final minimum. Every stage holds its own
// valid bit, so a stalled output fills bubbles first and back-pressure reaches req_chan.ready
// only when all stages are full. The mode register is always writable and is sampled as an
// item enters.

module vector_median_window_select_core import vmws_pkg::*; #(
   parameter int WINDOW_WIDTH  = 3,
   parameter int WINDOW_HEIGHT = 3,
   parameter int CHANNEL_COUNT = 3
) (
   input  logic       clock,
   input  logic       reset,
   vmws_req_if.sink   req_chan,
   vmws_rsp_if.source rsp_chan,
   vmws_csr_if.sink   csr_chan
);

   localparam int           HALF_W    = WINDOW_WIDTH / 2;
   localparam int           HALF_H    = WINDOW_HEIGHT / 2;
   localparam pos_mask_type WIN_MASK  = window_mask(HALF_W, HALF_H);
   localparam pixel_type    CHAN_MASK = chan_keep(CHANNEL_COUNT);

   distance_mode_type   mode_ff;
   distance_mode_type   mode_1_ff;
   logic [NUM_STAGES:1] vld_in;
   logic [NUM_STAGES:1] vld_ff;
   stage_ctl_type       ctl;

   pixel_type     req_pix [NUM_POS];
   pos_mask_type  req_used;
   pixel_type     pix_ff  [ST_DIFF:ST_TOTAL][NUM_POS];
   pos_mask_type  used_ff [ST_DIFF:ST_TOTAL];
   pair_dist_type pair_dist [NUM_PAIRS];
   logic [PART_W-1:0] part_in [NUM_POS][PART_N];
   logic [PART_W-1:0] part_ff [NUM_POS][PART_N];
   total_type     total_in [NUM_POS];
   total_type     total_ff [NUM_POS];
   result_type    result;

   assign req_pix[0] = req_chan.pixel_0;
   assign req_pix[1] = req_chan.pixel_1;
   assign req_pix[2] = req_chan.pixel_2;
   assign req_pix[3] = req_chan.pixel_3;
   assign req_pix[4] = req_chan.pixel_4;
   assign req_pix[5] = req_chan.pixel_5;
   assign req_pix[6] = req_chan.pixel_6;
   assign req_pix[7] = req_chan.pixel_7;
   assign req_pix[8] = req_chan.pixel_8;
   assign req_used   = req_chan.valid_mask & WIN_MASK;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ABS;
      end else if (csr_chan.valid) begin
         mode_ff <= distance_mode_type'(csr_chan.distance_mode);
      end
   end

   // stage enables, back to front
   always_comb begin
      ctl.en[NUM_STAGES] = !vld_ff[NUM_STAGES] || rsp_chan.ready;
      for (int s = NUM_STAGES - 1; s >= 1; s--) begin
         ctl.en[s] = !vld_ff[s] || ctl.en[s + 1];
      end
   end

   always_comb begin
      vld_in[1] = ctl.en[1] ? req_chan.valid : vld_ff[1];
      for (int s = 2; s <= NUM_STAGES; s++) begin
         vld_in[s] = ctl.en[s] ? vld_ff[s - 1] : vld_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_chan.ready = ctl.en[ST_DIFF];

   always_ff @(posedge clock) begin
      if (ctl.en[ST_DIFF]) begin
         pix_ff[ST_DIFF]  <= req_pix;
         used_ff[ST_DIFF] <= req_used;
         mode_1_ff        <= mode_ff;
      end
      for (int s = ST_DIFF + 1; s <= ST_TOTAL; s++) begin
         if (ctl.en[s]) begin
            pix_ff[s]  <= pix_ff[s - 1];
            used_ff[s] <= used_ff[s - 1];
         end
      end
   end

   for (genvar p = 0; p < NUM_PAIRS; p++) begin : g_pair
      vmws_pair_dist #(
         .CHANNEL_COUNT (CHANNEL_COUNT)
      ) u_pair (
         .clock     (clock),
         .ctl       (ctl),
         .pixel_a   (req_pix[PAIR_LO[p]]),
         .pixel_b   (req_pix[PAIR_HI[p]]),
         .pair_used (req_used[PAIR_LO[p]] && req_used[PAIR_HI[p]]),
         .mode      (mode_1_ff),
         .pair_dist (pair_dist[p])
      );
   end

   always_comb begin
      for (int k = 0; k < NUM_POS; k++) begin
         for (int h = 0; h < PART_N; h++) begin
            part_in[k][h] = '0;
            for (int i = 0; i < PART_SIZE; i++) begin
               part_in[k][h] = part_in[k][h] +
                               PART_W'(pair_dist[POS_PAIRS[k][h * PART_SIZE + i]]);
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_POS; k++) begin
         total_in[k] = '0;
         for (int h = 0; h < PART_N; h++) begin
            total_in[k] = total_in[k] + TOTAL_W'(part_ff[k][h]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en[ST_PART]) begin
         part_ff  <= part_in;
      end
      if (ctl.en[ST_TOTAL]) begin
         total_ff <= total_in;
      end
   end

   vmws_min_select u_min_select (
      .clock  (clock),
      .ctl    (ctl),
      .total  (total_ff),
      .pixel  (pix_ff[ST_TOTAL]),
      .used   (used_ff[ST_TOTAL]),
      .result (result)
   );

   assign rsp_chan.valid           = vld_ff[ST_OUT];
   assign rsp_chan.filtered_pixel  = result.pixel & CHAN_MASK;
   assign rsp_chan.chosen_position = result.pos;
   assign rsp_chan.least_total     = result.total;

endmodule

`default_nettype wire

// ===== rtl/core/vmws_checker.sv =====
// Port-level checks for the vector median window select core, bound to the top level.
`default_nettype none

module vmws_checker import vmws_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input pos_type chosen_position
);

   localparam pos_type LAST_POS = POS_W'(NUM_POS - 1);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("item dropped while output stalled");

   a_no_block: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input blocked although output is draining");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> chosen_position <= LAST_POS)
      else $error("chosen position outside the window");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("output valid straight after reset");

endmodule

bind vector_median_window_select_core vmws_checker u_vmws_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .chosen_position (rsp_chan.chosen_position)
);

`default_nettype wire
